FILE: hdl/bre_pkg.sv
`timescale 1ns / 1ps
// bre_pkg: shared types and constants of the blend ratio easer
// no dependencies; imported by bre_cmd_if and all modules of the block
package bre_pkg;

    localparam int OP_W  = 2;
    localparam int DUR_W = 16;

    typedef logic [OP_W-1:0]  op_t;
    typedef logic [DUR_W-1:0] dur_t;

    localparam op_t OP_TICK   = 2'd0;
    localparam op_t OP_START  = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;
    localparam op_t OP_MARK   = 2'd3;

    // status of a serial arithmetic unit as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

FILE: hdl/bre_cmd_if.sv
`timescale 1ns / 1ps
// bre_cmd_if: command channel of the blend ratio easer (op and duration)
// depends on bre_pkg
interface bre_cmd_if;
    import bre_pkg::*;

    logic valid;
    logic ready;
    op_t  op;
    dur_t duration;

    modport source (output valid, output op, output duration, input ready);
    modport sink   (input valid, input op, input duration, output ready);

endinterface

FILE: hdl/bre_res_if.sv
`timescale 1ns / 1ps
// bre_res_if: result channel of the blend ratio easer (ratios and flags)
// depends on nothing; width follows FRAC_BITS
interface bre_res_if #(
    parameter int FRAC_BITS = 16
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] scale_from;
    logic [FRAC_BITS:0] scale_to;
    logic               finished;
    logic               active;
    logic               blending;

    modport source (output valid, output scale_from, output scale_to, output finished,
                    output active, output blending, input ready);
    modport sink   (input valid, input scale_from, input scale_to, input finished,
                    input active, input blending, output ready);

endinterface

FILE: hdl/bre_mul_serial.sv
`timescale 1ns / 1ps
// bre_mul_serial: bit-serial shift-add multiplier giving floor(a * b / 2^FRAC_BITS)
// depends on bre_pkg (unit_stat_t)
module bre_mul_serial #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [FRAC_BITS:0]      a,
    input  logic [FRAC_BITS-1:0]    b,
    output logic [FRAC_BITS:0]      p,
    output bre_pkg::unit_stat_t     stat
);
    import bre_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [FRAC_BITS:0]   mcand_reg, mcand_next;
    logic [FRAC_BITS-1:0] mplier_reg, mplier_next;
    logic [FRAC_BITS:0]   hi_reg, hi_next;
    logic [FRAC_BITS+1:0] acc_sum;

    // high part of the product, one multiplier bit a cycle, low bits dropped
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        hi_next     = hi_reg;
        acc_sum     = {1'b0, hi_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = a;
            mplier_next = b;
            hi_next     = '0;
        end
        else if (busy_reg)
        begin
            hi_next     = acc_sum[FRAC_BITS+1:1];
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + CW'(1);
            if (cnt_reg == CW'(FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        hi_reg     <= hi_next;
    end

    assign p         = hi_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: hdl/bre_div_serial.sv
`timescale 1ns / 1ps
// bre_div_serial: restoring divider, one quotient bit a cycle, q = floor(a * 2^FRAC_BITS / b)
// depends on bre_pkg (unit_stat_t); needs a <= b and b nonzero
module bre_div_serial #(
    parameter int FRAC_BITS = 16,
    parameter int DIV_W     = 18
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIV_W-1:0]        a,
    input  logic [DIV_W-1:0]        b,
    output logic [FRAC_BITS:0]      q,
    output bre_pkg::unit_stat_t     stat
);
    import bre_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [DIV_W:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [FRAC_BITS:0]   quo_reg, quo_next;
    logic                 ge;
    logic [DIV_W:0]       rem_sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        ge        = rem_reg >= {1'b0, dvs_reg};
        // remainder stays below the divisor, so the shifted value fits
        rem_sub   = ge ? (rem_reg - {1'b0, dvs_reg}) : rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, a};
            dvs_next  = b;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = {rem_sub[DIV_W-1:0], 1'b0};
            quo_next = {quo_reg[FRAC_BITS-1:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(FRAC_BITS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign q         = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: hdl/blend_ratio_easer.sv
`timescale 1ns / 1ps
// blend_ratio_easer: crossfade ratio generator, unsigned fixed point with FRAC_BITS fraction bits
// work before res.valid: a tick that continues a blend runs two serial multiplies and three
//   serial divides, a start with a nonzero duration one serial divide, other commands none
// throughput: one word at a time, set by the shared serial units
// a finished word waits in the output register while the next command is taken
// reset: weight 0, phase and to ratio one, from ratio and step 0, flags clear
// depends on bre_pkg, bre_cmd_if, bre_res_if, bre_mul_serial, bre_div_serial
module blend_ratio_easer #(
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    bre_cmd_if.sink   cmd,
    bre_res_if.source res
);
    import bre_pkg::*;

    localparam int RW    = FRAC_BITS + 1;
    localparam int DIV_W = (FRAC_BITS + 2 > DUR_W) ? FRAC_BITS + 2 : DUR_W;
    localparam logic [RW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_STEP = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_DIVD = 4'd4;
    localparam logic [3:0] S_PREP = 4'd5;
    localparam logic [3:0] S_DIVF = 4'd6;
    localparam logic [3:0] S_DIVT = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [RW-1:0] weight_reg, weight_next;
    logic [RW-1:0] phase_reg, phase_next;
    logic [RW-1:0] step_reg, step_next;
    logic [RW-1:0] from_reg, from_next;
    logic [RW-1:0] to_reg, to_next;
    logic          active_reg, active_next;
    logic          blending_reg, blending_next;
    logic [RW-1:0] wn_reg, wn_next;
    logic [RW-1:0] d_reg, d_next;
    logic [RW-1:0] s_reg, s_next;
    logic          res_valid_reg, res_valid_next;
    logic [RW-1:0] out_from_reg;
    logic [RW-1:0] out_to_reg;
    logic          out_fin_reg;
    logic          out_act_reg;
    logic          out_blend_reg;

    logic                 load_out;
    logic [RW:0]          psum;
    logic [RW:0]          ds_sum;
    logic [RW-1:0]        wn_calc;

    logic                 mul_start;
    logic [RW-1:0]        mul_a;
    logic [FRAC_BITS-1:0] mul_b;
    logic [RW-1:0]        mul_p;
    unit_stat_t           mul_stat;

    logic                 div_start;
    logic [DIV_W-1:0]     div_a;
    logic [DIV_W-1:0]     div_b;
    logic [RW-1:0]        div_q;
    unit_stat_t           div_stat;

    bre_mul_serial #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .stat  (mul_stat)
    );

    bre_div_serial #(
        .FRAC_BITS (FRAC_BITS),
        .DIV_W     (DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .q     (div_q),
        .stat  (div_stat)
    );

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        weight_next   = weight_reg;
        phase_next    = phase_reg;
        step_next     = step_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        active_next   = active_reg;
        blending_next = blending_reg;
        wn_next       = wn_reg;
        d_next        = d_reg;
        s_next        = s_reg;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        div_a         = '0;
        div_b         = '0;
        load_out      = 1'b0;
        psum          = {1'b0, phase_reg} + {1'b0, step_reg};
        ds_sum        = {1'b0, d_reg} + {1'b0, s_reg};
        wn_calc       = weight_reg - mul_p;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_DONE;
                    unique case (cmd.op)
                        OP_TICK:
                        begin
                            if (weight_reg != '0)
                            begin
                                if (psum[RW:FRAC_BITS] != '0)
                                begin
                                    // phase reached one: blend over
                                    weight_next = '0;
                                    phase_next  = ONE;
                                    from_next   = '0;
                                    to_next     = ONE;
                                end
                                else
                                begin
                                    phase_next    = psum[RW-1:0];
                                    blending_next = 1'b1;
                                    mul_start     = 1'b1;
                                    mul_a         = weight_reg;
                                    mul_b         = psum[FRAC_BITS-1:0];
                                    state_next    = S_MUL1;
                                end
                            end
                        end
                        OP_START:
                        begin
                            if (cmd.duration == '0)
                            begin
                                weight_next = '0;
                                phase_next  = ONE;
                                from_next   = '0;
                                to_next     = ONE;
                            end
                            else
                            begin
                                weight_next   = ONE;
                                phase_next    = '0;
                                from_next     = ONE;
                                to_next       = '0;
                                blending_next = 1'b1;
                                div_start     = 1'b1;
                                div_a         = DIV_W'(1);
                                div_b         = DIV_W'(cmd.duration);
                                state_next    = S_STEP;
                            end
                        end
                        OP_REMOVE:
                        begin
                            active_next = 1'b0;
                            weight_next = '0;
                            phase_next  = ONE;
                            from_next   = '0;
                            to_next     = ONE;
                        end
                        OP_MARK:
                        begin
                            active_next   = 1'b1;
                            blending_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                if (div_stat.done)
                begin
                    // a step of zero would never end the blend
                    step_next  = (div_q == '0) ? RW'(1) : div_q;
                    state_next = S_DONE;
                end
            end
            S_MUL1:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_p;
                    mul_b      = phase_reg[FRAC_BITS-1:0];
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (mul_stat.done)
                begin
                    wn_next    = wn_calc;
                    div_start  = 1'b1;
                    div_a      = DIV_W'(wn_calc);
                    div_b      = DIV_W'(weight_reg);
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_stat.done)
                begin
                    d_next      = div_q;
                    s_next      = ONE - wn_reg;
                    weight_next = wn_reg;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                div_start  = 1'b1;
                div_a      = DIV_W'(d_reg);
                div_b      = DIV_W'(ds_sum);
                state_next = S_DIVF;
            end
            S_DIVF:
            begin
                if (div_stat.done)
                begin
                    from_next  = div_q;
                    div_start  = 1'b1;
                    div_a      = DIV_W'(s_reg);
                    div_b      = DIV_W'(ds_sum);
                    state_next = S_DIVT;
                end
            end
            S_DIVT:
            begin
                if (div_stat.done)
                begin
                    to_next    = div_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand the word over once the output register is free
                if (!res_valid_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            weight_reg    <= '0;
            phase_reg     <= ONE;
            step_reg      <= '0;
            from_reg      <= '0;
            to_reg        <= ONE;
            active_reg    <= 1'b0;
            blending_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            weight_reg    <= weight_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            from_reg      <= from_next;
            to_reg        <= to_next;
            active_reg    <= active_next;
            blending_reg  <= blending_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wn_reg <= wn_next;
        d_reg  <= d_next;
        s_reg  <= s_next;
        if (load_out)
        begin
            out_from_reg  <= from_reg;
            out_to_reg    <= to_reg;
            out_fin_reg   <= (weight_reg == '0);
            out_act_reg   <= active_reg;
            out_blend_reg <= blending_reg;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.scale_from = out_from_reg;
    assign res.scale_to   = out_to_reg;
    assign res.finished   = out_fin_reg;
    assign res.active     = out_act_reg;
    assign res.blending   = out_blend_reg;

`ifndef SYNTHESIS
    // floored ratios never add up to more than one
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (({1'b0, res.scale_from} + {1'b0, res.scale_to}) <= {1'b0, ONE}))
    else $error("ratio sum above one");

    // an ended blend always shows the incoming pose in full
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.finished) |-> (res.scale_from == '0 && res.scale_to == ONE))
    else $error("finished word with partial ratios");

    // the multiplier and the divider are never busy together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && div_stat.busy))
    else $error("arithmetic units overlap");

    // a running blend keeps its phase below one between words
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && weight_reg != '0) |-> (phase_reg < ONE))
    else $error("phase at or above one while blending");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for blend_ratio_easer, a directed table then random words
// depends on bre_pkg, bre_cmd_if, bre_res_if and the blend_ratio_easer rtl
module testbench;
    import bre_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int N_DIR        = 25;
    localparam int N_RANDOM     = 1450;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 1000;
    localparam int QUIET_LO     = 500;
    localparam int QUIET_HI     = 700;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 200;

    typedef logic [FRAC_BITS:0] ratio_t;

    localparam ratio_t      R0  = '0;
    localparam ratio_t      R1  = ratio_t'(1) << FRAC_BITS;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    typedef struct packed {
        ratio_t scale_from;
        ratio_t scale_to;
        logic   finished;
        logic   active;
        logic   blending;
    } blend_out_t;

    typedef struct packed {
        op_t        op;
        dur_t       dur;
        logic       typed;
        blend_out_t want;
    } cmd_row_t;

    logic clk;
    logic rst_n;

    bre_cmd_if cmd_ch();
    bre_res_if #(.FRAC_BITS(FRAC_BITS)) res_ch();

    blend_ratio_easer #(.FRAC_BITS(FRAC_BITS)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // own copy of the easer state
    logic [63:0] w_now;
    logic [63:0] ph_now;
    logic [63:0] ph_step;
    logic [63:0] from_r;
    logic [63:0] to_r;
    logic        act_f;
    logic        blend_f;

    cmd_row_t   cmd_q[$];
    blend_out_t ratio_q[$];
    cmd_row_t   dir_rows [N_DIR];
    int         fail_cnt = 0;
    int         words_rx = 0;

    function automatic void clear_ratios();
        w_now  = 0;
        ph_now = ONE;
        from_r = 0;
        to_r   = ONE;
    endfunction

    function automatic blend_out_t ease_step(op_t op, dur_t dur);
        logic [63:0] prev;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] d;
        logic [63:0] s;
        case (op)
            OP_TICK:
                if (w_now != 0)
                begin
                    ph_now = ph_now + ph_step;
                    if (ph_now >= ONE)
                        clear_ratios();
                    else
                    begin
                        blend_f = 1'b1;
                        prev    = w_now;
                        p       = (prev * ph_now) >> FRAC_BITS;
                        q       = (p * ph_now) >> FRAC_BITS;
                        w_now   = prev - q;
                        d       = (w_now << FRAC_BITS) / prev;
                        s       = ONE - w_now;
                        from_r  = (d << FRAC_BITS) / (d + s);
                        to_r    = (s << FRAC_BITS) / (d + s);
                    end
                end
            OP_START:
                if (dur == 0)
                    clear_ratios();
                else
                begin
                    w_now   = ONE;
                    ph_now  = 0;
                    from_r  = ONE;
                    to_r    = 0;
                    blend_f = 1'b1;
                    ph_step = ONE / 64'(dur);
                    // step never drops to zero, so every blend ends
                    if (ph_step == 0)
                        ph_step = 1;
                end
            OP_REMOVE:
            begin
                act_f = 1'b0;
                clear_ratios();
            end
            OP_MARK:
            begin
                act_f   = 1'b1;
                blend_f = 1'b0;
            end
            default: ;
        endcase
        return '{from_r[FRAC_BITS:0], to_r[FRAC_BITS:0], w_now == 0, act_f, blend_f};
    endfunction

    function automatic void push_cmd(op_t op, dur_t dur);
        cmd_row_t row;
        row     = '0;
        row.op  = op;
        row.dur = dur;
        cmd_q.push_back(row);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // command side: builds the stimulus, drives it and records what each word should give
    initial
    begin
        int         i;
        int         k;
        int         gap;
        int         kind;
        int         n_ticks;
        dur_t       dur;
        blend_out_t want;

        rst_n           <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.op       <= OP_TICK;
        cmd_ch.duration <= '0;

        dir_rows = '{
            '{OP_TICK,   16'h0000, 1'b1, '{R0, R1, 1'b1, 1'b0, 1'b0}},
            '{OP_REMOVE, 16'hFFFF, 1'b1, '{R0, R1, 1'b1, 1'b0, 1'b0}},
            '{OP_MARK,   16'h0000, 1'b1, '{R0, R1, 1'b1, 1'b1, 1'b0}},
            '{OP_START,  16'h0000, 1'b1, '{R0, R1, 1'b1, 1'b1, 1'b0}},
            '{OP_START,  16'h0001, 1'b1, '{R1, R0, 1'b0, 1'b1, 1'b1}},
            '{OP_TICK,   16'hFFFF, 1'b1, '{R0, R1, 1'b1, 1'b1, 1'b1}},
            '{OP_TICK,   16'h0000, 1'b1, '{R0, R1, 1'b1, 1'b1, 1'b1}},
            '{OP_MARK,   16'hAAAA, 1'b1, '{R0, R1, 1'b1, 1'b1, 1'b0}},
            '{OP_START,  16'hFFFF, 1'b1, '{R1, R0, 1'b0, 1'b1, 1'b1}},
            '{OP_TICK,   16'h0000, 1'b0, '0},
            '{OP_TICK,   16'h5555, 1'b0, '0},
            '{OP_START,  16'h0002, 1'b1, '{R1, R0, 1'b0, 1'b1, 1'b1}},
            '{OP_TICK,   16'h0000, 1'b0, '0},
            '{OP_TICK,   16'h0000, 1'b1, '{R0, R1, 1'b1, 1'b1, 1'b1}},
            '{OP_START,  16'h0003, 1'b1, '{R1, R0, 1'b0, 1'b1, 1'b1}},
            '{OP_MARK,   16'h0000, 1'b1, '{R1, R0, 1'b0, 1'b1, 1'b0}},
            '{OP_TICK,   16'h0000, 1'b0, '0},
            '{OP_TICK,   16'hAAAA, 1'b0, '0},
            '{OP_REMOVE, 16'h5555, 1'b1, '{R0, R1, 1'b1, 1'b0, 1'b1}},
            '{OP_START,  16'hAAAA, 1'b1, '{R1, R0, 1'b0, 1'b0, 1'b1}},
            '{OP_TICK,   16'h0000, 1'b0, '0},
            '{OP_START,  16'h5555, 1'b1, '{R1, R0, 1'b0, 1'b0, 1'b1}},
            '{OP_START,  16'h0000, 1'b1, '{R0, R1, 1'b1, 1'b0, 1'b1}},
            '{OP_START,  16'h8000, 1'b1, '{R1, R0, 1'b0, 1'b0, 1'b1}},
            '{OP_TICK,   16'h0000, 1'b0, '0}
        };
        foreach (dir_rows[j])
            cmd_q.push_back(dir_rows[j]);

        // mostly whole blends with random lengths, mixed with noise and blends cut short
        while (cmd_q.size() < N_DIR + N_RANDOM)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                if ($urandom_range(9) == 0)
                    dur = dur_t'($urandom_range(25, 65535));
                else
                    dur = dur_t'($urandom_range(1, 24));
                push_cmd(OP_START, dur);
                n_ticks = (dur > 38) ? 40 : int'(dur) + $urandom_range(0, 2);
                for (k = 0; k < n_ticks; k++)
                begin
                    if ($urandom_range(19) == 0)
                        push_cmd(OP_MARK, dur_t'($urandom));
                    push_cmd(OP_TICK, dur_t'($urandom));
                end
            end
            else if (kind < 85)
                push_cmd(op_t'($urandom_range(3)), dur_t'($urandom));
            else
            begin
                push_cmd(OP_START, dur_t'($urandom_range(2, 30)));
                n_ticks = $urandom_range(0, 3);
                for (k = 0; k < n_ticks; k++)
                    push_cmd(OP_TICK, dur_t'($urandom));
                case ($urandom_range(2))
                    0:       push_cmd(OP_REMOVE, dur_t'($urandom));
                    1:       push_cmd(OP_START, '0);
                    default: push_cmd(OP_START, dur_t'($urandom_range(1, 65535)));
                endcase
            end
        end

        w_now   = 0;
        ph_now  = ONE;
        ph_step = 0;
        from_r  = 0;
        to_r    = ONE;
        act_f   = 1'b0;
        blend_f = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < cmd_q.size(); i++)
        begin
            gap = 0;
            if (i < QUIET_LO || i >= QUIET_HI)
                while ($urandom_range(99) < 38)
                    gap++;
            if (gap > 0 || i == PAUSE_AT)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                // let the block drain completely before carrying on
                if (i == PAUSE_AT)
                begin
                    do @(posedge clk); while (ratio_q.size() != 0);
                end
            end
            cmd_ch.valid    <= 1'b1;
            cmd_ch.op       <= cmd_q[i].op;
            cmd_ch.duration <= cmd_q[i].dur;
            do @(posedge clk); while (!cmd_ch.ready);
            want = ease_step(cmd_q[i].op, cmd_q[i].dur);
            ratio_q.push_back(cmd_q[i].typed ? cmd_q[i].want : want);
        end
        cmd_ch.valid <= 1'b0;

        while (ratio_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: random back-pressure, one long hold-off, and the comparison
    initial
    begin
        blend_out_t got;
        blend_out_t want;
        logic       hold_done;

        hold_done     = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                words_rx++;
                got = '{res_ch.scale_from, res_ch.scale_to, res_ch.finished,
                        res_ch.active, res_ch.blending};
                if (ratio_q.size() == 0)
                begin
                    $display("%0t: unexpected word, got from %0d to %0d fin %0b act %0b bl %0b",
                             $time, got.scale_from, got.scale_to, got.finished, got.active,
                             got.blending);
                    fail_cnt++;
                end
                else
                begin
                    want = ratio_q.pop_front();
                    if (got.scale_from !== want.scale_from)
                    begin
                        $display("%0t: scale_from expected %0d got %0d",
                                 $time, want.scale_from, got.scale_from);
                        fail_cnt++;
                    end
                    if (got.scale_to !== want.scale_to)
                    begin
                        $display("%0t: scale_to expected %0d got %0d",
                                 $time, want.scale_to, got.scale_to);
                        fail_cnt++;
                    end
                    if (got.finished !== want.finished)
                    begin
                        $display("%0t: finished expected %0b got %0b",
                                 $time, want.finished, got.finished);
                        fail_cnt++;
                    end
                    if (got.active !== want.active)
                    begin
                        $display("%0t: active expected %0b got %0b",
                                 $time, want.active, got.active);
                        fail_cnt++;
                    end
                    if (got.blending !== want.blending)
                    begin
                        $display("%0t: blending expected %0b got %0b",
                                 $time, want.blending, got.blending);
                        fail_cnt++;
                    end
                end
            end
            if (words_rx == HOLD_AT && !hold_done)
            begin
                // long hold so the block backs up and stalls its command side
                hold_done     = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= (words_rx >= QUIET_LO && words_rx < QUIET_HI) ||
                                ($urandom_range(99) >= 38);
        end
    end

    // watchdog on cycles in which neither channel moves a word
    initial
    begin
        int stalled;

        stalled = 0;
        wait (rst_n === 1'b1);
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
